// ----- rtl/huffman_code_builder_top_assert.svh -----
// Assertion macros used by the huffman code builder datapath.
`ifndef HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define HCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/hcb_pkg.sv -----
`default_nettype none

package hcb_pkg;

    localparam int HCB_MAX_SYMBOLS = 64;
    localparam int SYM_W    = 8;
    localparam int FREQ_W   = 24;
    localparam int WEIGHT_W = 30;
    localparam int CODE_W   = 63;
    localparam int LEN_W    = 6;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HINIT,
        OP_HDEC,
        OP_CUR_I,
        OP_SD_STEP,
        OP_TM_A,
        OP_TM_B,
        OP_SUM,
        OP_SU_PUT,
        OP_SU_STEP,
        OP_ROOT,
        OP_EMIT,
        OP_KIDS,
        OP_POP,
        OP_POPD
    } op_t;

    // Heap read address select
    typedef enum logic [1:0] {
        RD_I,
        RD_KIDS,
        RD_TM,
        RD_PARENT
    } rsel_t;

    typedef struct packed {
        op_t   op;
        rsel_t rsel;
    } cmd_t;

    typedef struct packed {
        logic sd_done;
        logic i_zero;
        logic multi;
        logic pos_zero;
        logic su_less;
        logic is_leaf;
        logic stack_empty;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/huffman_code_builder_top.sv -----
// Load: one symbol/frequency transaction per cycle while s_ready is high.
// Build: heapify, then N-1 merges, each of two extract-min sift-downs and one
// sift-up, every heap level taking a read state and a compare state.
// Walk: visits each tree node, one code per leaf, stalled by m_ready.
// aresetn (synchronous, active low) clears control state; RAM contents persist.
`default_nettype none

module huffman_code_builder_top
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = HCB_MAX_SYMBOLS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire logic [FREQ_W-1:0] s_frequency,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [SYM_W-1:0]       m_out_symbol,
    output logic [CODE_W-1:0]      m_code_bits,
    output logic [LEN_W-1:0]       m_code_length,
    output logic                   m_end_of_table
);

    // The controller sequences load, heapify, merge and tree walk; the
    // datapath holds the heap, tree, symbol and walk stack memories.
    // Heap entries carry {weight, node} so a compare needs a single read.
    // The finished code sits in an output register, so a new table may start
    // loading while the final code of the previous one waits.
    cmd_t  cmd;
    stat_t stat;

    hcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_symbol       (s_symbol),
        .s_frequency    (s_frequency),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_code_bits    (m_code_bits),
        .m_code_length  (m_code_length),
        .m_end_of_table (m_end_of_table)
    );

endmodule

`default_nettype wire

// ----- rtl/hcb_ram.sv -----
`default_nettype none

module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/hcb_ctrl.sv -----
`default_nettype none

module hcb_ctrl
    import hcb_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_last,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [19:0] {
        S_LOAD    = 20'h00001,
        S_HINIT   = 20'h00002,
        S_HD_RD   = 20'h00004,
        S_HD_CUR  = 20'h00008,
        S_SD_RD   = 20'h00010,
        S_SD_CMP  = 20'h00020,
        S_HD_DEC  = 20'h00040,
        S_MCHK    = 20'h00080,
        S_TM_RD   = 20'h00100,
        S_TM_SET  = 20'h00200,
        S_SUM     = 20'h00400,
        S_SU_CHK  = 20'h00800,
        S_SU_CMP  = 20'h01000,
        S_ROOT_RD = 20'h02000,
        S_ROOT    = 20'h04000,
        S_W_TEST  = 20'h08000,
        S_W_LEAF  = 20'h10000,
        S_W_KIDS  = 20'h20000,
        S_W_POP   = 20'h40000,
        S_W_POPD  = 20'h80000
    } state_t;

    // Where a sift-down returns to
    typedef enum logic [1:0] {
        RET_HEAP,
        RET_TA,
        RET_TB
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    assign s_ready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        cmd.rsel   = RD_I;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (s_last) begin
                        state_next = S_HINIT;
                    end
                end
            end
            S_HINIT: begin
                cmd.op     = OP_HINIT;
                state_next = S_HD_RD;
            end
            S_HD_RD: begin
                cmd.rsel   = RD_I;
                state_next = S_HD_CUR;
            end
            S_HD_CUR: begin
                cmd.op     = OP_CUR_I;
                ret_next   = RET_HEAP;
                state_next = S_SD_RD;
            end
            S_SD_RD: begin
                cmd.rsel   = RD_KIDS;
                state_next = S_SD_CMP;
            end
            S_SD_CMP: begin
                cmd.op   = OP_SD_STEP;
                cmd.rsel = RD_KIDS;
                if (!stat.sd_done) begin
                    state_next = S_SD_RD;
                end else begin
                    case (ret_reg)
                        RET_HEAP: state_next = stat.i_zero ? S_MCHK : S_HD_DEC;
                        RET_TA: begin
                            ret_next   = RET_TB;
                            state_next = S_TM_RD;
                        end
                        default: state_next = S_SUM;
                    endcase
                end
            end
            S_HD_DEC: begin
                cmd.op     = OP_HDEC;
                state_next = S_HD_RD;
            end
            S_MCHK: begin
                if (stat.multi) begin
                    ret_next   = RET_TA;
                    state_next = S_TM_RD;
                end else begin
                    state_next = S_ROOT_RD;
                end
            end
            S_TM_RD: begin
                cmd.rsel   = RD_TM;
                state_next = S_TM_SET;
            end
            S_TM_SET: begin
                cmd.op     = (ret_reg == RET_TA) ? OP_TM_A : OP_TM_B;
                state_next = S_SD_RD;
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_SU_CHK;
            end
            S_SU_CHK: begin
                cmd.rsel = RD_PARENT;
                if (stat.pos_zero) begin
                    cmd.op     = OP_SU_PUT;
                    state_next = S_MCHK;
                end else begin
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                cmd.op     = OP_SU_STEP;
                cmd.rsel   = RD_PARENT;
                state_next = stat.su_less ? S_SU_CHK : S_MCHK;
            end
            S_ROOT_RD: begin
                cmd.rsel   = RD_TM;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd.op     = OP_ROOT;
                state_next = S_W_TEST;
            end
            S_W_TEST: begin
                state_next = stat.is_leaf ? S_W_LEAF : S_W_KIDS;
            end
            S_W_LEAF: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = stat.stack_empty ? S_LOAD : S_W_POP;
                end
            end
            S_W_KIDS: begin
                cmd.op     = OP_KIDS;
                state_next = S_W_TEST;
            end
            S_W_POP: begin
                cmd.op     = OP_POP;
                state_next = S_W_POPD;
            end
            S_W_POPD: begin
                cmd.op     = OP_POPD;
                state_next = S_W_TEST;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            ret_reg   <= RET_HEAP;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcb_dp.sv -----
`default_nettype none

module hcb_dp
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = HCB_MAX_SYMBOLS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire logic [FREQ_W-1:0] s_frequency,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [SYM_W-1:0]       m_out_symbol,
    output logic [CODE_W-1:0]      m_code_bits,
    output logic [LEN_W-1:0]       m_code_length,
    output logic                   m_end_of_table
);

    localparam int IDX_W  = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int ENT_W  = WEIGHT_W + NODE_W;
    localparam int STK_W  = NODE_W + LEN_W + CODE_W;

    // control registers
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             m_valid_reg, m_valid_next;

    // payload registers
    logic [NODE_W-1:0]   next_reg, next_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [WEIGHT_W-1:0] cur_w_reg, cur_w_next;
    logic [NODE_W-1:0]   cur_n_reg, cur_n_next;
    logic [WEIGHT_W-1:0] a_w_reg, a_w_next, b_w_reg, b_w_next;
    logic [NODE_W-1:0]   a_n_reg, a_n_next, b_n_reg, b_n_next;
    logic [LEN_W-1:0]    wk_d_reg, wk_d_next;
    logic [CODE_W-1:0]   wk_c_reg, wk_c_next;
    logic [SYM_W-1:0]    m_sym_reg, m_sym_next;
    logic [CODE_W-1:0]   m_code_reg, m_code_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;
    logic                m_end_reg, m_end_next;

    // memory ports
    logic                  heap_we;
    logic [IDX_W-1:0]      heap_waddr, heap_raddr_a, heap_raddr_b;
    logic [ENT_W-1:0]      heap_wdata, heap_rd_a, heap_rd_b;
    logic                  sym_we;
    logic [SYM_W-1:0]      sym_rd;
    logic                  kid_we;
    logic [2*NODE_W-1:0]   kid_rd;
    logic                  stk_we;
    logic [STK_W-1:0]      stk_wdata, stk_rd;

    logic [IDX_W+1:0]    l_pos, r_pos, cnt_ext;
    logic                l_ok, r_ok, pick_l, pick_r;
    logic [WEIGHT_W-1:0] w_a, w_b, min_w, sum_w;
    logic [IDX_W-1:0]    parent;
    logic [CNT_W-1:0]    n_minus2;
    logic [IDX_W-1:0]    start_idx;
    logic                room;
    logic [ENT_W-1:0]    cur_ent, sd_wdata;

    assign w_a     = heap_rd_a[ENT_W-1:NODE_W];
    assign w_b     = heap_rd_b[ENT_W-1:NODE_W];
    assign cur_ent = {cur_w_reg, cur_n_reg};
    assign l_pos   = {1'b0, pos_reg, 1'b1};
    assign r_pos   = l_pos + 1'b1;
    assign cnt_ext = (IDX_W+2)'(cnt_reg);
    assign l_ok    = (l_pos < cnt_ext);
    assign r_ok    = (r_pos < cnt_ext);
    assign pick_l  = l_ok && (w_a < cur_w_reg);
    assign min_w   = pick_l ? w_a : cur_w_reg;
    assign pick_r  = r_ok && (w_b < min_w);
    assign sd_wdata = pick_r ? heap_rd_b : (pick_l ? heap_rd_a : cur_ent);
    assign parent  = (pos_reg - 1'b1) >> 1;
    assign sum_w   = a_w_reg + b_w_reg;
    assign n_minus2  = loaded_reg - CNT_W'(2);
    assign start_idx = (loaded_reg >= CNT_W'(2)) ? IDX_W'(n_minus2 >> 1) : '0;
    assign room    = (loaded_reg < CNT_W'(MAX_SYMBOLS));

    assign stat.sd_done     = !pick_l && !pick_r;
    assign stat.i_zero      = (i_reg == '0);
    assign stat.multi       = (cnt_reg > CNT_W'(1));
    assign stat.pos_zero    = (pos_reg == '0);
    assign stat.su_less     = (cur_w_reg < w_a);
    assign stat.is_leaf     = (cur_n_reg < NODE_W'(loaded_reg));
    assign stat.stack_empty = (sp_reg == '0);
    assign stat.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.rsel)
            RD_I: begin
                heap_raddr_a = i_reg;
                heap_raddr_b = IDX_W'(cnt_reg - 1'b1);
            end
            RD_KIDS: begin
                heap_raddr_a = l_pos[IDX_W-1:0];
                heap_raddr_b = r_pos[IDX_W-1:0];
            end
            RD_PARENT: begin
                heap_raddr_a = parent;
                heap_raddr_b = IDX_W'(cnt_reg - 1'b1);
            end
            default: begin
                heap_raddr_a = '0;
                heap_raddr_b = IDX_W'(cnt_reg - 1'b1);
            end
        endcase
    end

    always_comb begin
        loaded_next  = loaded_reg;
        cnt_next     = cnt_reg;
        sp_next      = sp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        next_next    = next_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        cur_w_next   = cur_w_reg;
        cur_n_next   = cur_n_reg;
        a_w_next     = a_w_reg;
        a_n_next     = a_n_reg;
        b_w_next     = b_w_reg;
        b_n_next     = b_n_reg;
        wk_d_next    = wk_d_reg;
        wk_c_next    = wk_c_reg;
        m_sym_next   = m_sym_reg;
        m_code_next  = m_code_reg;
        m_len_next   = m_len_reg;
        m_end_next   = m_end_reg;
        heap_we      = 1'b0;
        heap_waddr   = pos_reg;
        heap_wdata   = cur_ent;
        sym_we       = 1'b0;
        kid_we       = 1'b0;
        stk_we       = 1'b0;
        stk_wdata    = {kid_rd[NODE_W-1:0], wk_d_reg + 1'b1, {wk_c_reg[CODE_W-2:0], 1'b1}};
        case (cmd.op)
            OP_LOAD: begin
                if (room) begin
                    heap_we     = 1'b1;
                    heap_waddr  = IDX_W'(loaded_reg);
                    heap_wdata  = {WEIGHT_W'(s_frequency), NODE_W'(loaded_reg)};
                    sym_we      = 1'b1;
                    loaded_next = loaded_reg + 1'b1;
                end
            end
            OP_HINIT: begin
                cnt_next  = loaded_reg;
                i_next    = start_idx;
                next_next = NODE_W'(loaded_reg);
            end
            OP_HDEC: i_next = i_reg - 1'b1;
            OP_CUR_I: begin
                {cur_w_next, cur_n_next} = heap_rd_a;
                pos_next = i_reg;
            end
            OP_SD_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = sd_wdata;
                if (pick_r) begin
                    pos_next = r_pos[IDX_W-1:0];
                end else if (pick_l) begin
                    pos_next = l_pos[IDX_W-1:0];
                end
            end
            OP_TM_A: begin
                {a_w_next, a_n_next}     = heap_rd_a;
                {cur_w_next, cur_n_next} = heap_rd_b;
                cnt_next = cnt_reg - 1'b1;
                pos_next = '0;
            end
            OP_TM_B: begin
                {b_w_next, b_n_next}     = heap_rd_a;
                {cur_w_next, cur_n_next} = heap_rd_b;
                cnt_next = cnt_reg - 1'b1;
                pos_next = '0;
            end
            OP_SUM: begin
                kid_we     = 1'b1;
                cur_w_next = sum_w;
                cur_n_next = next_reg;
                pos_next   = IDX_W'(cnt_reg);
                cnt_next   = cnt_reg + 1'b1;
                next_next  = next_reg + 1'b1;
            end
            OP_SU_PUT: heap_we = 1'b1;
            OP_SU_STEP: begin
                heap_we = 1'b1;
                if (stat.su_less) begin
                    heap_wdata = heap_rd_a;
                    pos_next   = parent;
                end
            end
            OP_ROOT: begin
                cur_n_next = heap_rd_a[NODE_W-1:0];
                wk_d_next  = '0;
                wk_c_next  = '0;
                sp_next    = '0;
            end
            OP_EMIT: begin
                m_valid_next = 1'b1;
                m_sym_next   = sym_rd;
                m_code_next  = wk_c_reg;
                m_len_next   = wk_d_reg;
                m_end_next   = (sp_reg == '0);
                if (sp_reg == '0) begin
                    loaded_next = '0;
                    cnt_next    = '0;
                end
            end
            OP_KIDS: begin
                stk_we     = 1'b1;
                sp_next    = sp_reg + 1'b1;
                cur_n_next = kid_rd[2*NODE_W-1:NODE_W];
                wk_d_next  = wk_d_reg + 1'b1;
                wk_c_next  = {wk_c_reg[CODE_W-2:0], 1'b0};
            end
            OP_POP: sp_next = sp_reg - 1'b1;
            OP_POPD: {cur_n_next, wk_d_next, wk_c_next} = stk_rd;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg  <= '0;
            cnt_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            loaded_reg  <= loaded_next;
            cnt_reg     <= cnt_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        next_reg   <= next_next;
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        cur_w_reg  <= cur_w_next;
        cur_n_reg  <= cur_n_next;
        a_w_reg    <= a_w_next;
        a_n_reg    <= a_n_next;
        b_w_reg    <= b_w_next;
        b_n_reg    <= b_n_next;
        wk_d_reg   <= wk_d_next;
        wk_c_reg   <= wk_c_next;
        m_sym_reg  <= m_sym_next;
        m_code_reg <= m_code_next;
        m_len_reg  <= m_len_next;
        m_end_reg  <= m_end_next;
    end

    // two copies of the heap give two read ports
    hcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SYMBOLS)) u_heap_a (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr_a),
        .rdata (heap_rd_a)
    );

    hcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SYMBOLS)) u_heap_b (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr_b),
        .rdata (heap_rd_b)
    );

    hcb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym (
        .aclk  (aclk),
        .we    (sym_we),
        .waddr (IDX_W'(loaded_reg)),
        .wdata (s_symbol),
        .raddr (cur_n_reg[IDX_W-1:0]),
        .rdata (sym_rd)
    );

    hcb_ram #(.WIDTH(2*NODE_W), .DEPTH(NODES)) u_kids (
        .aclk  (aclk),
        .we    (kid_we),
        .waddr (next_reg),
        .wdata ({a_n_reg, b_n_reg}),
        .raddr (cur_n_reg),
        .rdata (kid_rd)
    );

    hcb_ram #(.WIDTH(STK_W), .DEPTH(MAX_SYMBOLS)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (sp_reg[IDX_W-1:0]),
        .wdata (stk_wdata),
        .raddr (IDX_W'(sp_reg - 1'b1)),
        .rdata (stk_rd)
    );

    assign m_valid        = m_valid_reg;
    assign m_out_symbol   = m_sym_reg;
    assign m_code_bits    = m_code_reg;
    assign m_code_length  = m_len_reg;
    assign m_end_of_table = m_end_reg;

`include "huffman_code_builder_top_assert.svh"

    `HCB_ASSERT(a_heap_le_loaded, cnt_reg <= loaded_reg, "heap count exceeds loaded count")
    `HCB_ASSERT(a_loaded_max, loaded_reg <= CNT_W'(MAX_SYMBOLS), "loaded count overflow")
    `HCB_ASSERT(a_emit_leaf, (cmd.op == OP_EMIT) |-> stat.is_leaf, "emit on internal node")
    `HCB_ASSERT_ALWAYS(a_rst_out, !aresetn |=> !m_valid_reg, "output valid after reset")

endmodule

`default_nettype wire
